FILE: sv/hhh_pkg.sv
// ----------------------------------------------------------------------------
// hhh_pkg
// Types and constants shared by the heavy-hitter sketch insert core.
// ----------------------------------------------------------------------------
package hhh_pkg;

    localparam int unsigned BUCKET_COUNT     = 1024;
    localparam int unsigned CELLS_PER_BUCKET = 8;
    localparam int unsigned LEVEL_COUNT      = 5;

    localparam int unsigned BKT_W  = 10;
    localparam int unsigned CELL_W = 3;
    localparam int unsigned LVL_W  = 3;
    localparam int unsigned USED_W = 4;
    localparam int unsigned CFG_W  = 3;

    localparam logic [31:0] MIX_MUL  = 32'h5bd1_e995;
    localparam logic [63:0] DRAW_MAX = 64'h0000_0000_7FFF_FFFF;
    localparam logic [31:0] CNT_MAX  = 32'hFFFF_FFFF;

    // register indexes
    localparam logic [CFG_W-1:0] REG_SEED   = 3'd0;
    localparam logic [CFG_W-1:0] REG_MASK_0 = 3'd1;
    localparam logic [CFG_W-1:0] REG_MASK_1 = 3'd2;
    localparam logic [CFG_W-1:0] REG_MASK_2 = 3'd3;
    localparam logic [CFG_W-1:0] REG_MASK_3 = 3'd4;
    localparam logic [CFG_W-1:0] REG_MASK_4 = 3'd5;

    typedef enum logic [2:0] {
        ACT_FILL  = 3'd0,
        ACT_MATCH = 3'd1,
        ACT_REPL  = 3'd2,
        ACT_KEEP  = 3'd3,
        ACT_READ  = 3'd4
    } act_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HSTART,
        ST_HWAIT,
        ST_READ,
        ST_LOAD,
        ST_SCAN,
        ST_DECIDE,
        ST_JUDGE,
        ST_WRITE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [31:0]      count;
        logic [LVL_W-1:0] level;
        logic [31:0]      key;
    } cell_t;

    typedef struct packed {
        logic [USED_W-1:0]                used;
        cell_t [CELLS_PER_BUCKET-1:0]     cells;
    } row_t;

    typedef struct packed {
        logic             start;
        logic [31:0]      seed;
        logic [LVL_W-1:0] level;
        logic [31:0]      mkey;
    } hash_req_t;

    typedef struct packed {
        logic             done;
        logic [BKT_W-1:0] bucket;
    } hash_rsp_t;

endpackage

FILE: sv/hhh_ram.sv
// ----------------------------------------------------------------------------
// hhh_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module hhh_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wr_data,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/hhh_hash.sv
// ----------------------------------------------------------------------------
// hhh_hash
// Bucket hash over level and masked key, one shared multiplier, one
// multiply per cycle.
// ----------------------------------------------------------------------------
module hhh_hash (
    input  logic              aclk,
    input  logic              aresetn,
    input  hhh_pkg::hash_req_t req,
    output hhh_pkg::hash_rsp_t rsp
);

    logic        busy_reg, busy_next;
    logic [2:0]  step_reg, step_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] tmp_reg, tmp_next;
    logic [31:0] mul_in;
    logic [31:0] mul_out;
    logic [31:0] fin;

    assign mul_out = mul_in * hhh_pkg::MIX_MUL;
    assign fin     = acc_reg ^ (acc_reg >> 15);

    always_comb begin
        mul_in    = acc_reg;
        busy_next = busy_reg;
        step_next = step_reg;
        acc_next  = acc_reg;
        tmp_next  = tmp_reg;
        if (req.start) begin
            busy_next = 1'b1;
            step_next = 3'd0;
            acc_next  = req.seed ^ 32'd8;
        end else if (busy_reg) begin
            step_next = step_reg + 3'd1;
            case (step_reg)
                3'd0: begin
                    mul_in   = {29'd0, req.level};
                    tmp_next = mul_out;
                end
                3'd1, 3'd4: begin
                    mul_in   = tmp_reg ^ (tmp_reg >> 24);
                    tmp_next = mul_out;
                end
                3'd2, 3'd5: begin
                    mul_in   = acc_reg;
                    acc_next = mul_out ^ tmp_reg;
                end
                3'd3: begin
                    mul_in   = req.mkey;
                    tmp_next = mul_out;
                end
                3'd6: begin
                    mul_in   = acc_reg ^ (acc_reg >> 13);
                    acc_next = mul_out;
                end
                default: begin
                    busy_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= 3'd0;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
        acc_reg <= acc_next;
        tmp_reg <= tmp_next;
    end

    assign rsp.done   = busy_reg && (step_reg == 3'd7) && !req.start;
    assign rsp.bucket = fin[hhh_pkg::BKT_W-1:0];

endmodule

FILE: sv/hierarchical_heavy_hitter_insert_core.sv
// ----------------------------------------------------------------------------
// hierarchical_heavy_hitter_insert_core
// Flow: an insert runs hash start and the 8-step hash, bucket row read, then
// either a free-cell fill or a scan of up to 8 cells with a replacement check if
// none match, then write back; a read request goes straight to the row read.
// Throughput: one request at a time; the next is taken after the result leaves.
// Reset: synchronous, active low; then a pass over all 1024 buckets clears the bucket
// memory, during which no request is taken (configuration writes are taken).
// ----------------------------------------------------------------------------
module hierarchical_heavy_hitter_insert_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // flow_key[31:0], hier_level[34:32], replace_draw[65:35],
    // read_bucket[75:66], read_cell[78:76]
    input  logic [79:0] s_tdata,
    // mode[0]
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // bucket_index[9:0], cell_index[12:10], cell_key[44:13],
    // cell_level[47:45], cell_count[79:48]
    output logic [79:0] m_tdata,
    // action[2:0]
    output logic [2:0]  m_tuser
);

    localparam int unsigned ROW_W = $bits(hhh_pkg::row_t);

    hhh_pkg::state_t state_reg, state_next;

    logic [31:0] seed_reg;
    logic [31:0] mask_reg [hhh_pkg::LEVEL_COUNT];

    logic                       mode_reg;
    logic [31:0]                key_reg;
    logic [hhh_pkg::LVL_W-1:0]  lvl_reg;
    logic [31:0]                lmask_reg;
    logic [31:0]                mkey_reg;
    logic [30:0]                draw_reg;
    logic [hhh_pkg::BKT_W-1:0]  bkt_reg;
    logic [hhh_pkg::CELL_W-1:0] cell_reg;
    hhh_pkg::act_t              act_reg;
    hhh_pkg::row_t              row_reg;
    logic [hhh_pkg::CELL_W-1:0] idx_reg;
    logic [hhh_pkg::CELL_W-1:0] min_idx_reg;
    logic [31:0]                min_val_reg;
    logic [63:0]                prod_reg;
    logic [hhh_pkg::BKT_W-1:0]  clr_reg;

    logic [hhh_pkg::LVL_W-1:0]  in_lvl;
    logic                       accept;

    hhh_pkg::hash_req_t hreq;
    hhh_pkg::hash_rsp_t hrsp;

    logic                      ram_we;
    logic                      ram_re;
    logic [hhh_pkg::BKT_W-1:0] ram_addr;
    logic [ROW_W-1:0]          ram_wdata;
    logic [ROW_W-1:0]          ram_rdata;
    hhh_pkg::row_t             rd_row;
    hhh_pkg::row_t             load_row;
    logic                      fill_now;

    hhh_pkg::cell_t scan_cell;
    logic           scan_match;
    logic           scan_min;
    hhh_pkg::cell_t out_cell;
    logic [hhh_pkg::CELL_W-1:0] fill_idx;

    assign accept = s_tvalid && s_tready;
    assign in_lvl = (s_tdata[34:32] >= hhh_pkg::LVL_W'(hhh_pkg::LEVEL_COUNT))
                  ? hhh_pkg::LVL_W'(hhh_pkg::LEVEL_COUNT - 1) : s_tdata[34:32];

    assign rd_row     = hhh_pkg::row_t'(ram_rdata);
    assign fill_idx   = hhh_pkg::CELL_W'(hhh_pkg::CELLS_PER_BUCKET - 1)
                      - rd_row.used[hhh_pkg::CELL_W-1:0];
    assign fill_now   = !mode_reg
                     && (rd_row.used < hhh_pkg::USED_W'(hhh_pkg::CELLS_PER_BUCKET));
    assign scan_cell  = row_reg.cells[idx_reg];
    assign scan_match = (scan_cell.level == lvl_reg)
                     && ((scan_cell.key & lmask_reg) == mkey_reg);
    assign scan_min   = (idx_reg == '0) || (scan_cell.count < min_val_reg);

    always_comb begin
        load_row = rd_row;
        if (fill_now) begin
            // fill the next free cell, counting down from the top
            load_row.used            = rd_row.used + 1'b1;
            load_row.cells[fill_idx] = '{count: 32'd1, level: lvl_reg, key: key_reg};
        end
    end

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg    <= 32'd0;
            mask_reg[0] <= 32'hFFFF_FFFF;
            mask_reg[1] <= 32'hFFFF_FF00;
            mask_reg[2] <= 32'hFFFF_0000;
            mask_reg[3] <= 32'hFF00_0000;
            mask_reg[4] <= 32'h0000_0000;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                hhh_pkg::REG_SEED:   seed_reg    <= cfg_wdata;
                hhh_pkg::REG_MASK_0: mask_reg[0] <= cfg_wdata;
                hhh_pkg::REG_MASK_1: mask_reg[1] <= cfg_wdata;
                hhh_pkg::REG_MASK_2: mask_reg[2] <= cfg_wdata;
                hhh_pkg::REG_MASK_3: mask_reg[3] <= cfg_wdata;
                hhh_pkg::REG_MASK_4: mask_reg[4] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            hhh_pkg::ST_CLEAR: begin
                if (clr_reg == '1) state_next = hhh_pkg::ST_IDLE;
            end
            hhh_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = s_tuser[0] ? hhh_pkg::ST_READ : hhh_pkg::ST_HSTART;
                end
            end
            hhh_pkg::ST_HSTART: state_next = hhh_pkg::ST_HWAIT;
            hhh_pkg::ST_HWAIT: begin
                if (hrsp.done) state_next = hhh_pkg::ST_READ;
            end
            hhh_pkg::ST_READ: state_next = hhh_pkg::ST_LOAD;
            hhh_pkg::ST_LOAD: begin
                if (mode_reg) begin
                    state_next = hhh_pkg::ST_OUT;
                end else if (rd_row.used < hhh_pkg::USED_W'(hhh_pkg::CELLS_PER_BUCKET)) begin
                    state_next = hhh_pkg::ST_WRITE;
                end else begin
                    state_next = hhh_pkg::ST_SCAN;
                end
            end
            hhh_pkg::ST_SCAN: begin
                if (scan_match) begin
                    state_next = hhh_pkg::ST_WRITE;
                end else if (idx_reg == '1) begin
                    state_next = hhh_pkg::ST_DECIDE;
                end
            end
            hhh_pkg::ST_DECIDE: state_next = hhh_pkg::ST_JUDGE;
            hhh_pkg::ST_JUDGE:  state_next = hhh_pkg::ST_WRITE;
            hhh_pkg::ST_WRITE:  state_next = hhh_pkg::ST_OUT;
            hhh_pkg::ST_OUT: begin
                if (m_tready) state_next = hhh_pkg::ST_IDLE;
            end
            default: state_next = hhh_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_tready  = 1'b0;
        m_tvalid  = 1'b0;
        hreq      = '{start: 1'b0, seed: seed_reg, level: lvl_reg, mkey: mkey_reg};
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_addr  = bkt_reg;
        ram_wdata = row_reg;
        unique case (state_reg)
            hhh_pkg::ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_addr  = clr_reg;
                ram_wdata = '0;
            end
            hhh_pkg::ST_IDLE:   s_tready   = 1'b1;
            hhh_pkg::ST_HSTART: hreq.start = 1'b1;
            hhh_pkg::ST_READ:   ram_re     = 1'b1;
            hhh_pkg::ST_WRITE:  ram_we     = 1'b1;
            hhh_pkg::ST_OUT:    m_tvalid   = 1'b1;
            default: ;
        endcase
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= hhh_pkg::ST_CLEAR;
            clr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == hhh_pkg::ST_CLEAR) clr_reg <= clr_reg + 1'b1;
        end

        case (state_reg)
            hhh_pkg::ST_IDLE: begin
                mode_reg  <= s_tuser[0];
                key_reg   <= s_tdata[31:0];
                lvl_reg   <= in_lvl;
                lmask_reg <= mask_reg[in_lvl];
                mkey_reg  <= s_tdata[31:0] & mask_reg[in_lvl];
                draw_reg  <= s_tdata[65:35];
                bkt_reg   <= s_tdata[75:66];
                cell_reg  <= s_tdata[78:76];
                act_reg   <= hhh_pkg::ACT_READ;
            end
            hhh_pkg::ST_HWAIT: begin
                if (hrsp.done) bkt_reg <= hrsp.bucket;
            end
            hhh_pkg::ST_LOAD: begin
                row_reg <= load_row;
                idx_reg <= '0;
                if (fill_now) begin
                    cell_reg <= fill_idx;
                    act_reg  <= hhh_pkg::ACT_FILL;
                end
            end
            hhh_pkg::ST_SCAN: begin
                idx_reg <= idx_reg + 1'b1;
                if (scan_match) begin
                    if (scan_cell.count != hhh_pkg::CNT_MAX) begin
                        row_reg.cells[idx_reg].count <= scan_cell.count + 32'd1;
                    end
                    cell_reg <= idx_reg;
                    act_reg  <= hhh_pkg::ACT_MATCH;
                end else if (scan_min) begin
                    min_idx_reg <= idx_reg;
                    min_val_reg <= scan_cell.count;
                end
            end
            hhh_pkg::ST_DECIDE: begin
                // draw < MAX/count  <=>  (draw+1)*count <= MAX
                prod_reg <= {32'd0, {1'b0, draw_reg} + 32'd1} * {32'd0, min_val_reg};
            end
            hhh_pkg::ST_JUDGE: begin
                cell_reg <= min_idx_reg;
                if (min_val_reg == 32'd0 || prod_reg <= hhh_pkg::DRAW_MAX) begin
                    // keep the count, take the new key and level
                    row_reg.cells[min_idx_reg] <= '{count: row_reg.cells[min_idx_reg].count,
                                                    level: lvl_reg, key: key_reg};
                    act_reg                    <= hhh_pkg::ACT_REPL;
                end else begin
                    act_reg <= hhh_pkg::ACT_KEEP;
                end
            end
            default: ;
        endcase
    end

    hhh_hash u_hash (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (hreq),
        .rsp     (hrsp)
    );

    hhh_ram #(
        .WIDTH (ROW_W),
        .DEPTH (hhh_pkg::BUCKET_COUNT)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .rd_en   (ram_re),
        .addr    (ram_addr),
        .wr_data (ram_wdata),
        .rd_data (ram_rdata)
    );

    assign out_cell = row_reg.cells[cell_reg];
    assign m_tdata  = {out_cell.count, out_cell.level, out_cell.key, cell_reg, bkt_reg};
    assign m_tuser  = act_reg;

endmodule

FILE: verif/hhh_insert_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hhh_insert_checker
// Watches the request, result and register ports of the heavy-hitter insert
// core. Keeps its own copy of the bucket memory, predicts the result of every
// accepted request, and compares each result in order.
// ----------------------------------------------------------------------------
module hhh_insert_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [79:0] s_tdata,
    input  logic [0:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [79:0] m_tdata,
    input  logic [2:0]  m_tuser,
    output int          errors,
    output int          pending
);

    typedef struct packed {
        hhh_pkg::act_t act;
        logic [9:0]    bkt;
        logic [2:0]    cidx;
        logic [31:0]   key;
        logic [2:0]    lvl;
        logic [31:0]   cnt;
    } cell_report_t;

    localparam int TOTAL_CELLS = hhh_pkg::BUCKET_COUNT * hhh_pkg::CELLS_PER_BUCKET;

    logic [31:0] seed;
    logic [31:0] lvl_mask [hhh_pkg::LEVEL_COUNT];
    logic [31:0] mem_key  [TOTAL_CELLS];
    logic [2:0]  mem_lvl  [TOTAL_CELLS];
    logic [31:0] mem_cnt  [TOTAL_CELLS];
    logic [3:0]  free_left [hhh_pkg::BUCKET_COUNT];

    cell_report_t expected_q [$];
    cell_report_t want, got;

    function automatic logic [31:0] mix(input logic [31:0] h, input logic [31:0] k);
        k = k * hhh_pkg::MIX_MUL;
        k = k ^ (k >> 24);
        k = k * hhh_pkg::MIX_MUL;
        h = h * hhh_pkg::MIX_MUL;
        return h ^ k;
    endfunction

    function automatic logic [9:0] hash_bucket(input logic [31:0] hseed,
                                               input logic [31:0] mkey,
                                               input logic [2:0]  lvl);
        logic [31:0] h;
        h = hseed ^ 32'd8;
        h = mix(h, {29'd0, lvl});
        h = mix(h, mkey);
        h = h ^ (h >> 13);
        h = h * hhh_pkg::MIX_MUL;
        h = h ^ (h >> 15);
        return h[9:0];
    endfunction

    function automatic cell_report_t report(input hhh_pkg::act_t act, input logic [9:0] b,
                                            input logic [2:0] c);
        cell_report_t r;
        int slot;
        slot = b * hhh_pkg::CELLS_PER_BUCKET + c;
        r.act  = act;
        r.bkt  = b;
        r.cidx = c;
        r.key  = mem_key[slot];
        r.lvl  = mem_lvl[slot];
        r.cnt  = mem_cnt[slot];
        return r;
    endfunction

    function automatic cell_report_t predict_request(input logic mode,
                                                     input logic [79:0] d);
        logic [31:0] key, mask, mkey, min_cnt;
        logic [2:0]  lvl, min_cell;
        logic [30:0] draw;
        logic [9:0]  b;
        int          base, s;
        key  = d[31:0];
        lvl  = d[34:32];
        draw = d[65:35];
        if (mode)
            return report(hhh_pkg::ACT_READ, d[75:66], d[78:76]);
        if (lvl >= hhh_pkg::LEVEL_COUNT)
            lvl = 3'(hhh_pkg::LEVEL_COUNT - 1);
        mask = lvl_mask[lvl];
        mkey = key & mask;
        b    = hash_bucket(seed, mkey, lvl);
        base = b * hhh_pkg::CELLS_PER_BUCKET;
        if (free_left[b] != 4'd0) begin
            free_left[b] = free_left[b] - 4'd1;
            s = base + free_left[b];
            mem_key[s] = key;
            mem_lvl[s] = lvl;
            mem_cnt[s] = 32'd1;
            return report(hhh_pkg::ACT_FILL, b, free_left[b][2:0]);
        end
        min_cell = '0;
        min_cnt  = '0;
        for (int i = 0; i < hhh_pkg::CELLS_PER_BUCKET; i++) begin
            s = base + i;
            if (mem_lvl[s] == lvl && (mem_key[s] & mask) == mkey) begin
                if (mem_cnt[s] != hhh_pkg::CNT_MAX)
                    mem_cnt[s] = mem_cnt[s] + 32'd1;
                return report(hhh_pkg::ACT_MATCH, b, 3'(i));
            end
            if (i == 0 || mem_cnt[s] < min_cnt) begin
                min_cnt  = mem_cnt[s];
                min_cell = 3'(i);
            end
        end
        if (min_cnt == 32'd0 || {1'b0, draw} < 32'h7FFF_FFFF / min_cnt) begin
            mem_key[base + min_cell] = key;
            mem_lvl[base + min_cell] = lvl;
            return report(hhh_pkg::ACT_REPL, b, min_cell);
        end
        return report(hhh_pkg::ACT_KEEP, b, min_cell);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            seed = 32'd0;
            lvl_mask[0] = 32'hFFFF_FFFF;
            lvl_mask[1] = 32'hFFFF_FF00;
            lvl_mask[2] = 32'hFFFF_0000;
            lvl_mask[3] = 32'hFF00_0000;
            lvl_mask[4] = 32'h0000_0000;
            for (int i = 0; i < TOTAL_CELLS; i++) begin
                mem_key[i] = '0;
                mem_lvl[i] = '0;
                mem_cnt[i] = '0;
            end
            for (int i = 0; i < hhh_pkg::BUCKET_COUNT; i++)
                free_left[i] = 4'(hhh_pkg::CELLS_PER_BUCKET);
            expected_q.delete();
            errors  = 0;
            pending = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    hhh_pkg::REG_SEED:   seed = cfg_wdata;
                    hhh_pkg::REG_MASK_0: lvl_mask[0] = cfg_wdata;
                    hhh_pkg::REG_MASK_1: lvl_mask[1] = cfg_wdata;
                    hhh_pkg::REG_MASK_2: lvl_mask[2] = cfg_wdata;
                    hhh_pkg::REG_MASK_3: lvl_mask[3] = cfg_wdata;
                    hhh_pkg::REG_MASK_4: lvl_mask[4] = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_q = {expected_q, predict_request(s_tuser[0], s_tdata)};
            if (m_tvalid && m_tready) begin
                got.act  = hhh_pkg::act_t'(m_tuser);
                got.bkt  = m_tdata[9:0];
                got.cidx = m_tdata[12:10];
                got.key  = m_tdata[44:13];
                got.lvl  = m_tdata[47:45];
                got.cnt  = m_tdata[79:48];
                if (expected_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: unexpected result act=%0d bkt=%0d cell=%0d",
                                 $time, got.act, got.bkt, got.cidx);
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want) begin
                        errors++;
                        if (errors <= 10)
                            $display({"%0t: mismatch exp act=%0d bkt=%0d cell=%0d ",
                                      "key=%h lvl=%0d cnt=%0d / got act=%0d bkt=%0d ",
                                      "cell=%0d key=%h lvl=%0d cnt=%0d"}, $time,
                                     want.act, want.bkt, want.cidx, want.key,
                                     want.lvl, want.cnt, got.act, got.bkt, got.cidx,
                                     got.key, got.lvl, got.cnt);
                    end
                end
            end
            pending = expected_q.size();
        end
    end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives insert and read requests into the heavy-hitter insert core under
// several register settings. Most random inserts are aimed at one bucket per phase
// so it fills, then matches, replaces and keeps; the checker judges results.
// ----------------------------------------------------------------------------
module testbench;

    localparam logic [2:0] REG_NONE = 3'd7;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_addr = '0;
    logic [31:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;
    logic [2:0]  m_tuser;
    int          errors, pending;

    logic        idle_on = 1'b1;
    logic        stuck = 1'b0;
    int          stall_left = 0;
    logic [31:0] cur_seed = 32'd0;
    logic [31:0] cur_mask [hhh_pkg::LEVEL_COUNT] = '{32'hFFFF_FFFF, 32'hFFFF_FF00,
                                                     32'hFFFF_0000, 32'hFF00_0000, 32'h0};
    logic [31:0] hot_key [12];
    logic [2:0]  hot_lvl [12];

    hierarchical_heavy_hitter_insert_core uut (.*);

    hhh_insert_checker chk (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // result side back-pressure in short bursts
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left <= int'($urandom_range(0, 3));
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_req(input logic mode, input logic [31:0] key,
                            input logic [2:0] lvl, input logic [30:0] draw,
                            input logic [9:0] rb, input logic [2:0] rc);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {1'b0, rc, rb, draw, lvl, key};
        do @(posedge aclk); while (!s_tready);
    endtask

    // hold requests until every result is back, then let the core settle
    task automatic drain();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        do begin
            @(negedge aclk);
            waited++;
        end while (pending != 0 && waited < 200000);
        if (pending != 0)
            stuck = 1'b1;
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    task automatic program_regs(input logic [31:0] seed, input logic [31:0] m0,
                                input logic [31:0] m1, input logic [31:0] m2,
                                input logic [31:0] m3, input logic [31:0] m4);
        write_reg(hhh_pkg::REG_SEED, seed);
        write_reg(hhh_pkg::REG_MASK_0, m0);
        write_reg(hhh_pkg::REG_MASK_1, m1);
        write_reg(hhh_pkg::REG_MASK_2, m2);
        write_reg(hhh_pkg::REG_MASK_3, m3);
        write_reg(hhh_pkg::REG_MASK_4, m4);
        write_reg(REG_NONE, $urandom);
        cfg_we <= 1'b0;
        cur_seed = seed;
        cur_mask = '{m0, m1, m2, m3, m4};
    endtask

    task automatic run_phase(input int n, input logic last_phase);
        int          tries, sel, pick;
        logic [31:0] key;
        logic [2:0]  lvl, sl;
        logic [30:0] draw;
        logic [9:0]  target;
        // collect keys that all land in one bucket
        target = 10'($urandom_range(0, hhh_pkg::BUCKET_COUNT - 1));
        for (int j = 0; j < 12; j++) begin
            lvl = 3'($urandom_range(0, 7));
            sl  = (lvl >= hhh_pkg::LEVEL_COUNT) ? 3'(hhh_pkg::LEVEL_COUNT - 1) : lvl;
            tries = 0;
            do begin
                key = $urandom;
                tries++;
            end while (chk.hash_bucket(cur_seed, key & cur_mask[sl], sl) != target
                       && tries < 20000);
            hot_key[j] = key;
            hot_lvl[j] = lvl;
        end
        for (int i = 0; i < n; i++) begin
            if (last_phase && i >= n - 100)
                idle_on = 1'b0;
            case ($urandom_range(0, 3))
                0, 1:    draw = 31'($urandom);
                2:       draw = 31'($urandom_range(0, 15));
                default: draw = 31'(32'h7FFF_FFFF - $urandom_range(0, 15));
            endcase
            sel = $urandom_range(0, 99);
            if (sel < 70) begin
                pick = $urandom_range(0, 11);
                send_req(1'b0, hot_key[pick], hot_lvl[pick], draw, 10'($urandom),
                         3'($urandom));
            end else if (sel < 85) begin
                send_req(1'b0, $urandom, 3'($urandom_range(0, 7)), draw, 10'($urandom),
                         3'($urandom));
            end else begin
                send_req(1'b1, $urandom, 3'($urandom), draw,
                         (sel < 92) ? target : 10'($urandom), 3'($urandom_range(0, 7)));
            end
        end
        drain();
    endtask

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: corner reads, key extremes, level saturation, and the
        // level-four bucket (mask all zero) filled past its eight cells
        send_req(1'b1, 32'h0, 3'd0, 31'd0, 10'd0, 3'd0);
        send_req(1'b1, 32'hFFFF_FFFF, 3'd7, 31'h7FFF_FFFF, 10'd1023, 3'd7);
        send_req(1'b0, 32'h0, 3'd0, 31'd0, 10'd0, 3'd0);
        send_req(1'b0, 32'hFFFF_FFFF, 3'd0, 31'h7FFF_FFFF, 10'd1023, 3'd7);
        send_req(1'b0, 32'hFFFF_FFFF, 3'd7, 31'd5, 10'd0, 3'd0);
        send_req(1'b0, 32'hA5A5_5A5A, 3'd5, 31'd5, 10'd0, 3'd0);
        send_req(1'b0, 32'h1234_5678, 3'd6, 31'd5, 10'd0, 3'd0);
        send_req(1'b0, 32'h0A0B_0C0D, 3'd3, 31'd0, 10'd0, 3'd0);
        send_req(1'b0, 32'h0A0B_FFFF, 3'd3, 31'd0, 10'd0, 3'd0);
        send_req(1'b0, 32'hC0A8_0101, 3'd1, 31'd0, 10'd0, 3'd0);
        send_req(1'b0, 32'hC0A8_0133, 3'd2, 31'd0, 10'd0, 3'd0);
        for (int k = 0; k < 10; k++)
            send_req(1'b0, $urandom, 3'd4, (k & 1) ? 31'h7FFF_FFFF : 31'd0,
                     10'd0, 3'd0);
        send_req(1'b1, 32'h0, 3'd0, 31'd0, chk.hash_bucket(32'd0, 32'd0, 3'd4), 3'd7);
        send_req(1'b1, 32'h0, 3'd0, 31'd0, chk.hash_bucket(32'd0, 32'd0, 3'd4), 3'd0);
        drain();

        program_regs(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF, 32'hFFFF_FFFF);
        run_phase(200, 1'b0);
        program_regs(32'hFFFF_FFFF, 32'h0, 32'h0000_00FF, 32'h0, 32'h0, 32'h0);
        run_phase(200, 1'b0);
        program_regs($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        run_phase(200, 1'b0);
        program_regs($urandom, 32'hFFFF_FFFF, 32'hFFFF_FF00, 32'hFFFF_0000,
                     32'hFF00_0000, 32'h0);
        run_phase(200, 1'b1);

        if (errors == 0 && pending == 0 && !stuck)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: hierarchical_heavy_hitter_insert_core.f
sv/hhh_pkg.sv
sv/hhh_ram.sv
sv/hhh_hash.sv
sv/hierarchical_heavy_hitter_insert_core.sv
verif/hhh_insert_checker.sv
verif/testbench.sv
